>>> rtl/core/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg
// Types and constants of the program map section parser.
// ----------------------------------------------------------------------------
package pmt_pkg;

    localparam int TDATA_W = 72;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_HDR   = 4'd1,
        PH_PROG  = 4'd2,
        PH_ES0   = 4'd3,
        PH_ES1   = 4'd4,
        PH_ES2   = 4'd5,
        PH_ES3   = 4'd6,
        PH_ES4   = 4'd7,
        PH_TAG   = 4'd8,
        PH_LEN   = 4'd9,
        PH_SKIP  = 4'd10,
        PH_LANG0 = 4'd11,
        PH_LANG1 = 4'd12,
        PH_LANG2 = 4'd13,
        PH_LANG3 = 4'd14,
        PH_DONE  = 4'd15
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_PROC,
        SQ_SCAN_RD,
        SQ_SCAN_CMP,
        SQ_EMIT
    } seq_t;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_STREAM = 3'd1,
        KIND_LANG   = 3'd2,
        KIND_BAD_ID = 3'd3,
        KIND_FULL   = 3'd4
    } kind_t;

    localparam logic [7:0]  TAG_ISO639    = 8'h0A;
    localparam logic [7:0]  LANG_MIN_LEN  = 8'd4;
    localparam logic [7:0]  TABLE_ID_RST  = 8'd2;
    localparam logic [11:0] POS_SECT_LEN  = 12'd2;
    localparam logic [11:0] POS_HDR_END   = 12'd11;

endpackage

>>> rtl/core/pmt_section_parser.sv
// ----------------------------------------------------------------------------
// pmt_section_parser
// Program map section parser with a persistent elementary stream PID table.
// ----------------------------------------------------------------------------
// Section bytes enter on the s_ channel, one item per byte, s_tuser high on
// the table id byte. Results leave on the m_ channel: m_tuser carries the
// kind, m_tdata the other fields. cfg_we writes the expected table id.
//
// Every byte is taken in the idle state and processed in the next cycle. The
// fifth byte of an elementary stream entry also walks the PID table through
// its single registered read port, a read step and a compare step a stored
// entry. A result passes through the emit step into the output register,
// after which the next byte is taken.
//
// Reset clears the parser state, the PID table count and the language flags,
// and sets the expected table id to 2. While the receiver stalls a result
// holds in the output register; a byte that yields another result waits in
// the sequencer until the register frees, and no byte is taken meanwhile.
// ----------------------------------------------------------------------------
module pmt_section_parser #(
    parameter int MAX_STREAMS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // data_byte
    input  logic                        s_tuser,   // section_start
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // pid[12:0], strm_type[20:13], info_length[30:21], entry_index[34:31],
    // is_new[35], language_code[59:36], aud_type[67:60], zero[71:68]
    output logic [pmt_pkg::TDATA_W-1:0] m_tdata,
    output logic [2:0]                  m_tuser,   // kind
    input  logic                        cfg_we,
    input  logic [7:0]                  cfg_wdata
);

    localparam int IDXW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int CNTW = $clog2(MAX_STREAMS + 1);
    localparam logic [CNTW-1:0] CountMax = CNTW'(MAX_STREAMS);

    function automatic logic [3:0] idx4(input logic [IDXW-1:0] i);
        logic [IDXW+3:0] w;
        w = {4'b0000, i};
        return w[3:0];
    endfunction

    function automatic pmt_pkg::phase_t after_desc(input logic [9:0] skip,
                                                   input logic [7:0] desc,
                                                   input pmt_pkg::phase_t cont);
        if (skip == 10'd0) begin
            return pmt_pkg::PH_ES0;
        end else if (desc == 8'd0) begin
            return pmt_pkg::PH_TAG;
        end
        return cont;
    endfunction

    pmt_pkg::seq_t   sq_reg, sq_next;
    pmt_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      exp_id_reg;
    logic [7:0]      byte_reg, byte_next;
    logic            start_reg, start_next;
    logic [11:0]     pos_reg, pos_next;
    logic [11:0]     loop_end_reg, loop_end_next;
    logic [9:0]      skip_reg, skip_next;
    logic [7:0]      desc_reg, desc_next;
    logic [7:0]      tag_reg, tag_next;
    logic [39:0]     hs_reg, hs_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [CNTW-1:0] scan_idx_reg, scan_idx_next;
    logic [IDXW-1:0] slot_reg, slot_next;
    logic            slot_ok_reg, slot_ok_next;
    logic [12:0]     cur_pid_reg, cur_pid_next;
    logic [MAX_STREAMS-1:0] lang_seen_reg, lang_seen_next;

    logic [12:0]     pid_mem [MAX_STREAMS];
    logic [12:0]     rd_data_reg;
    logic            mem_we;

    pmt_pkg::kind_t  res_kind_reg, res_kind_next;
    logic [12:0]     res_pid_reg, res_pid_next;
    logic [7:0]      res_st_reg, res_st_next;
    logic [9:0]      res_ilen_reg, res_ilen_next;
    logic [3:0]      res_idx_reg, res_idx_next;
    logic            res_new_reg, res_new_next;
    logic [23:0]     res_lang_reg, res_lang_next;
    logic [7:0]      res_atype_reg, res_atype_next;

    logic            m_valid_reg, m_valid_next;
    logic            out_load;
    pmt_pkg::kind_t  out_kind_reg;
    logic [12:0]     out_pid_reg;
    logic [7:0]      out_st_reg;
    logic [9:0]      out_ilen_reg;
    logic [3:0]      out_idx_reg;
    logic            out_new_reg;
    logic [23:0]     out_lang_reg;
    logic [7:0]      out_atype_reg;

    logic [39:0]     hs_shift;
    logic [11:0]     sect_len;
    logic [9:0]      skip_dec;
    logic [7:0]      desc_dec;
    logic            cap;

    assign s_tready = (sq_reg == pmt_pkg::SQ_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {4'b0000, out_atype_reg, out_lang_reg, out_new_reg, out_idx_reg,
                       out_ilen_reg, out_st_reg, out_pid_reg};

    assign hs_shift = {hs_reg[31:0], byte_reg};
    assign sect_len = hs_shift[11:0];
    assign skip_dec = skip_reg - 10'd1;
    assign desc_dec = desc_reg - 8'd1;
    assign cap      = (tag_reg == pmt_pkg::TAG_ISO639) && (byte_reg >= pmt_pkg::LANG_MIN_LEN)
                      && slot_ok_reg && !lang_seen_reg[slot_reg];

    always_comb begin
        sq_next        = sq_reg;
        phase_next     = phase_reg;
        byte_next      = byte_reg;
        start_next     = start_reg;
        pos_next       = pos_reg;
        loop_end_next  = loop_end_reg;
        skip_next      = skip_reg;
        desc_next      = desc_reg;
        tag_next       = tag_reg;
        hs_next        = hs_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        slot_next      = slot_reg;
        slot_ok_next   = slot_ok_reg;
        cur_pid_next   = cur_pid_reg;
        lang_seen_next = lang_seen_reg;
        mem_we         = 1'b0;
        res_kind_next  = res_kind_reg;
        res_pid_next   = res_pid_reg;
        res_st_next    = res_st_reg;
        res_ilen_next  = res_ilen_reg;
        res_idx_next   = res_idx_reg;
        res_new_next   = res_new_reg;
        res_lang_next  = res_lang_reg;
        res_atype_next = res_atype_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_load       = 1'b0;

        case (sq_reg)
            pmt_pkg::SQ_IDLE: begin
                if (s_tvalid) begin
                    byte_next  = s_tdata;
                    start_next = s_tuser;
                    sq_next    = pmt_pkg::SQ_PROC;
                end
            end
            pmt_pkg::SQ_PROC: begin
                sq_next        = pmt_pkg::SQ_IDLE;
                res_kind_next  = pmt_pkg::KIND_HEADER;
                res_pid_next   = 13'd0;
                res_st_next    = 8'd0;
                res_ilen_next  = 10'd0;
                res_idx_next   = 4'd0;
                res_new_next   = 1'b0;
                res_lang_next  = 24'd0;
                res_atype_next = 8'd0;
                if (start_reg) begin
                    pos_next = 12'd1;
                    hs_next  = 40'd0;
                    if (byte_reg != exp_id_reg) begin
                        phase_next    = pmt_pkg::PH_IDLE;
                        res_kind_next = pmt_pkg::KIND_BAD_ID;
                        sq_next       = pmt_pkg::SQ_EMIT;
                    end else begin
                        phase_next = pmt_pkg::PH_HDR;
                    end
                end else if (phase_reg == pmt_pkg::PH_IDLE || phase_reg == pmt_pkg::PH_DONE) begin
                    sq_next = pmt_pkg::SQ_IDLE;
                end else if (phase_reg == pmt_pkg::PH_HDR) begin
                    hs_next  = hs_shift;
                    pos_next = pos_reg + 12'd1;
                    if (pos_reg == pmt_pkg::POS_SECT_LEN) begin
                        loop_end_next = (sect_len != 12'd0) ? sect_len - 12'd1 : 12'd0;
                    end else if (pos_reg == pmt_pkg::POS_HDR_END) begin
                        skip_next     = hs_shift[9:0];
                        phase_next    = (hs_shift[9:0] != 10'd0) ? pmt_pkg::PH_PROG
                                                                 : pmt_pkg::PH_ES0;
                        res_pid_next  = hs_shift[28:16];
                        res_ilen_next = hs_shift[9:0];
                        sq_next       = pmt_pkg::SQ_EMIT;
                    end
                end else if (pos_reg >= loop_end_reg) begin
                    phase_next = pmt_pkg::PH_DONE;
                end else begin
                    pos_next = pos_reg + 12'd1;
                    case (phase_reg)
                        pmt_pkg::PH_PROG: begin
                            skip_next = skip_dec;
                            if (skip_dec == 10'd0) begin
                                phase_next = pmt_pkg::PH_ES0;
                            end
                        end
                        pmt_pkg::PH_ES0, pmt_pkg::PH_ES1, pmt_pkg::PH_ES2,
                        pmt_pkg::PH_ES3: begin
                            hs_next    = hs_shift;
                            phase_next = pmt_pkg::phase_t'(phase_reg + 4'd1);
                        end
                        pmt_pkg::PH_ES4: begin
                            hs_next       = hs_shift;
                            skip_next     = hs_shift[9:0];
                            phase_next    = (hs_shift[9:0] != 10'd0) ? pmt_pkg::PH_TAG
                                                                     : pmt_pkg::PH_ES0;
                            cur_pid_next  = hs_shift[28:16];
                            scan_idx_next = '0;
                            sq_next       = pmt_pkg::SQ_SCAN_RD;
                        end
                        pmt_pkg::PH_TAG: begin
                            tag_next   = byte_reg;
                            skip_next  = skip_dec;
                            phase_next = (skip_dec != 10'd0) ? pmt_pkg::PH_LEN
                                                             : pmt_pkg::PH_ES0;
                        end
                        pmt_pkg::PH_LEN: begin
                            desc_next  = byte_reg;
                            skip_next  = skip_dec;
                            hs_next    = 40'd0;
                            phase_next = after_desc(skip_dec, byte_reg,
                                                    cap ? pmt_pkg::PH_LANG0 : pmt_pkg::PH_SKIP);
                        end
                        pmt_pkg::PH_SKIP: begin
                            desc_next  = desc_dec;
                            skip_next  = skip_dec;
                            phase_next = after_desc(skip_dec, desc_dec, pmt_pkg::PH_SKIP);
                        end
                        pmt_pkg::PH_LANG0, pmt_pkg::PH_LANG1, pmt_pkg::PH_LANG2: begin
                            hs_next    = hs_shift;
                            desc_next  = desc_dec;
                            skip_next  = skip_dec;
                            phase_next = after_desc(skip_dec, desc_dec,
                                                    pmt_pkg::phase_t'(phase_reg + 4'd1));
                        end
                        pmt_pkg::PH_LANG3: begin
                            hs_next    = hs_shift;
                            desc_next  = desc_dec;
                            skip_next  = skip_dec;
                            phase_next = after_desc(skip_dec, desc_dec, pmt_pkg::PH_SKIP);
                            if (slot_ok_reg) begin
                                lang_seen_next[slot_reg] = 1'b1;
                                res_kind_next  = pmt_pkg::KIND_LANG;
                                res_pid_next   = cur_pid_reg;
                                res_idx_next   = idx4(slot_reg);
                                res_lang_next  = hs_shift[31:8];
                                res_atype_next = hs_shift[7:0];
                                sq_next        = pmt_pkg::SQ_EMIT;
                            end
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            pmt_pkg::SQ_SCAN_RD: begin
                res_pid_next   = hs_reg[28:16];
                res_st_next    = hs_reg[39:32];
                res_ilen_next  = hs_reg[9:0];
                res_lang_next  = 24'd0;
                res_atype_next = 8'd0;
                if (scan_idx_reg == count_reg) begin
                    sq_next = pmt_pkg::SQ_EMIT;
                    if (count_reg != CountMax) begin
                        mem_we                              = 1'b1;
                        lang_seen_next[count_reg[IDXW-1:0]] = 1'b0;
                        count_next    = count_reg + CNTW'(1);
                        slot_next     = count_reg[IDXW-1:0];
                        slot_ok_next  = 1'b1;
                        res_kind_next = pmt_pkg::KIND_STREAM;
                        res_idx_next  = idx4(count_reg[IDXW-1:0]);
                        res_new_next  = 1'b1;
                    end else begin
                        slot_ok_next  = 1'b0;
                        res_kind_next = pmt_pkg::KIND_FULL;
                        res_idx_next  = 4'd0;
                        res_new_next  = 1'b0;
                    end
                end else begin
                    sq_next = pmt_pkg::SQ_SCAN_CMP;
                end
            end
            pmt_pkg::SQ_SCAN_CMP: begin
                if (rd_data_reg == cur_pid_reg) begin
                    slot_next     = scan_idx_reg[IDXW-1:0];
                    slot_ok_next  = 1'b1;
                    res_kind_next = pmt_pkg::KIND_STREAM;
                    res_idx_next  = idx4(scan_idx_reg[IDXW-1:0]);
                    res_new_next  = 1'b0;
                    sq_next       = pmt_pkg::SQ_EMIT;
                end else begin
                    scan_idx_next = scan_idx_reg + CNTW'(1);
                    sq_next       = pmt_pkg::SQ_SCAN_RD;
                end
            end
            pmt_pkg::SQ_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    sq_next      = pmt_pkg::SQ_IDLE;
                end
            end
            default: begin
                sq_next = pmt_pkg::SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg        <= pmt_pkg::SQ_IDLE;
            phase_reg     <= pmt_pkg::PH_IDLE;
            exp_id_reg    <= pmt_pkg::TABLE_ID_RST;
            start_reg     <= 1'b0;
            pos_reg       <= 12'd0;
            loop_end_reg  <= 12'd0;
            skip_reg      <= 10'd0;
            desc_reg      <= 8'd0;
            tag_reg       <= 8'd0;
            hs_reg        <= 40'd0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            slot_reg      <= '0;
            slot_ok_reg   <= 1'b0;
            lang_seen_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            sq_reg        <= sq_next;
            phase_reg     <= phase_next;
            if (cfg_we) begin
                exp_id_reg <= cfg_wdata;
            end
            start_reg     <= start_next;
            pos_reg       <= pos_next;
            loop_end_reg  <= loop_end_next;
            skip_reg      <= skip_next;
            desc_reg      <= desc_next;
            tag_reg       <= tag_next;
            hs_reg        <= hs_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            slot_reg      <= slot_next;
            slot_ok_reg   <= slot_ok_next;
            lang_seen_reg <= lang_seen_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg       <= byte_next;
        cur_pid_reg    <= cur_pid_next;
        res_kind_reg   <= res_kind_next;
        res_pid_reg    <= res_pid_next;
        res_st_reg     <= res_st_next;
        res_ilen_reg   <= res_ilen_next;
        res_idx_reg    <= res_idx_next;
        res_new_reg    <= res_new_next;
        res_lang_reg   <= res_lang_next;
        res_atype_reg  <= res_atype_next;
        if (out_load) begin
            out_kind_reg  <= res_kind_reg;
            out_pid_reg   <= res_pid_reg;
            out_st_reg    <= res_st_reg;
            out_ilen_reg  <= res_ilen_reg;
            out_idx_reg   <= res_idx_reg;
            out_new_reg   <= res_new_reg;
            out_lang_reg  <= res_lang_reg;
            out_atype_reg <= res_atype_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pid_mem[count_reg[IDXW-1:0]] <= cur_pid_reg;
        end
        rd_data_reg <= pid_mem[scan_idx_reg[IDXW-1:0]];
    end

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item taken while previous item still in progress");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountMax)
        else $error("PID table count beyond capacity");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (sq_reg == pmt_pkg::SQ_SCAN_RD || sq_reg == pmt_pkg::SQ_SCAN_CMP)
        |-> scan_idx_reg <= count_reg)
        else $error("PID table scan past stored entries");

    a_lang_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (sq_reg == pmt_pkg::SQ_EMIT && res_kind_reg == pmt_pkg::KIND_LANG)
        |-> (slot_ok_reg && lang_seen_reg[slot_reg]))
        else $error("language result without its stream marked as seen");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(sq_reg == pmt_pkg::SQ_EMIT))
        else $error("result presented without passing the emit step");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the program map section parser.
// ----------------------------------------------------------------------------
// A short table of hand-built bytes covers bad table ids at both extremes, a
// header with the widest PCR PID, a first stream entry and its language
// descriptor, and a restart mid-section. Random sections follow: mostly well
// formed with random content, some with cut lengths, oversized info lengths,
// broken descriptors, wrong table ids, truncation and loose noise, under
// several table id settings. A bit-accurate section walker predicts each
// result not pinned by a hand-built row; every result leaving the block is
// compared field by field. Both channels idle at random but in one setting.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_STREAMS   = 16;
    localparam int SETTLE_CYCLES = 48;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_ITEMS   = 350;
    localparam int PID_POOL      = 20;

    typedef struct packed {
        pmt_pkg::kind_t kind;
        logic [12:0]    pid;
        logic [7:0]     stype;
        logic [9:0]     ilen;
        logic [3:0]     slot;
        logic           is_new;
        logic [23:0]    lang;
        logic [7:0]     atype;
    } parse_result_t;

    typedef struct {
        logic [7:0]    data;
        logic          sect_start;
        bit            pinned;
        parse_result_t pinned_res;
    } stim_row_t;

    logic                        aclk;
    logic                        aresetn   = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata   = 8'h00;
    logic                        s_tuser   = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [pmt_pkg::TDATA_W-1:0] m_tdata;
    logic [2:0]                  m_tuser;
    logic                        cfg_we    = 1'b0;
    logic [7:0]                  cfg_wdata = 8'h00;

    // section walker state
    logic [7:0]            table_id_cfg = pmt_pkg::TABLE_ID_RST;
    pmt_pkg::phase_t       sp_phase     = pmt_pkg::PH_IDLE;
    logic [11:0]           sp_pos       = '0;
    logic [11:0]           sp_loop_end  = '0;
    logic [9:0]            sp_skip      = '0;
    logic [7:0]            sp_desc_left = '0;
    logic [7:0]            sp_tag       = '0;
    logic [39:0]           sp_shift     = '0;
    logic [12:0]           pid_table [MAX_STREAMS];
    logic                  pid_used  [MAX_STREAMS];
    logic                  lang_done [MAX_STREAMS];
    logic [4:0]            pid_count    = '0;
    logic [4:0]            cur_slot     = '0;

    parse_result_t         section_results_q [$];
    stim_row_t             directed_rows [$];
    logic [12:0]           pid_pool [PID_POOL];
    bit                    no_gaps      = 1'b0;
    int                    items_sent   = 0;
    int                    mismatches   = 0;
    int                    stall_left   = 0;

    pmt_section_parser #(.MAX_STREAMS(MAX_STREAMS)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(9, 40);
    endfunction

    function automatic pmt_pkg::phase_t next_desc_phase(input pmt_pkg::phase_t cont);
        if (sp_skip == 0) return pmt_pkg::PH_ES0;
        if (sp_desc_left == 0) return pmt_pkg::PH_TAG;
        return cont;
    endfunction

    function automatic bit parse_section_byte(input logic [7:0] b, input logic sect_start,
                                              output parse_result_t r);
        logic [11:0] p;
        logic [12:0] pid;
        logic [9:0]  elen;
        logic        cap;
        bit          found;
        bit          hit;
        int          i;
        int          idx;
        r = '0;
        hit = 1'b0;
        if (sect_start) begin
            sp_pos = 12'd1;
            sp_shift = '0;
            if (b != table_id_cfg) begin
                sp_phase = pmt_pkg::PH_IDLE;
                r.kind = pmt_pkg::KIND_BAD_ID;
                return 1'b1;
            end
            sp_phase = pmt_pkg::PH_HDR;
            return 1'b0;
        end
        if (sp_phase == pmt_pkg::PH_IDLE || sp_phase == pmt_pkg::PH_DONE) return 1'b0;
        p = sp_pos;
        if (sp_phase == pmt_pkg::PH_HDR) begin
            sp_shift = {sp_shift[31:0], b};
            sp_pos = p + 12'd1;
            if (p == pmt_pkg::POS_SECT_LEN) begin
                sp_loop_end = (sp_shift[11:0] != 0) ? sp_shift[11:0] - 12'd1 : 12'd0;
            end else if (p == pmt_pkg::POS_HDR_END) begin
                sp_skip = sp_shift[9:0];
                sp_phase = (sp_shift[9:0] != 0) ? pmt_pkg::PH_PROG : pmt_pkg::PH_ES0;
                r.kind = pmt_pkg::KIND_HEADER;
                r.pid = sp_shift[28:16];
                r.ilen = sp_shift[9:0];
                return 1'b1;
            end
            return 1'b0;
        end
        if (p >= sp_loop_end) begin
            sp_phase = pmt_pkg::PH_DONE;
            return 1'b0;
        end
        sp_pos = p + 12'd1;
        case (sp_phase)
            pmt_pkg::PH_PROG: begin
                sp_skip--;
                if (sp_skip == 0) sp_phase = pmt_pkg::PH_ES0;
            end
            pmt_pkg::PH_ES0, pmt_pkg::PH_ES1, pmt_pkg::PH_ES2, pmt_pkg::PH_ES3: begin
                sp_shift = {sp_shift[31:0], b};
                sp_phase = pmt_pkg::phase_t'(sp_phase + 4'd1);
            end
            pmt_pkg::PH_ES4: begin
                sp_shift = {sp_shift[31:0], b};
                pid = sp_shift[28:16];
                elen = sp_shift[9:0];
                sp_skip = elen;
                sp_phase = (elen != 0) ? pmt_pkg::PH_TAG : pmt_pkg::PH_ES0;
                found = 1'b0;
                idx = 0;
                for (i = 0; i < MAX_STREAMS; i++) begin
                    if (!found && i < pid_count && pid_used[i[3:0]] &&
                        pid_table[i[3:0]] == pid) begin
                        found = 1'b1;
                        idx = i;
                    end
                end
                r.pid = pid;
                r.stype = sp_shift[39:32];
                r.ilen = elen;
                hit = 1'b1;
                if (found) begin
                    cur_slot = idx[4:0];
                    r.kind = pmt_pkg::KIND_STREAM;
                    r.slot = idx[3:0];
                end else if (pid_count < MAX_STREAMS) begin
                    pid_table[pid_count[3:0]] = pid;
                    pid_used[pid_count[3:0]] = 1'b1;
                    lang_done[pid_count[3:0]] = 1'b0;
                    cur_slot = pid_count;
                    r.kind = pmt_pkg::KIND_STREAM;
                    r.slot = pid_count[3:0];
                    r.is_new = 1'b1;
                    pid_count = pid_count + 5'd1;
                end else begin
                    cur_slot = 5'(MAX_STREAMS);
                    r.kind = pmt_pkg::KIND_FULL;
                end
            end
            pmt_pkg::PH_TAG: begin
                sp_tag = b;
                sp_skip--;
                sp_phase = (sp_skip != 0) ? pmt_pkg::PH_LEN : pmt_pkg::PH_ES0;
            end
            pmt_pkg::PH_LEN: begin
                cap = (sp_tag == pmt_pkg::TAG_ISO639) && (b >= pmt_pkg::LANG_MIN_LEN) &&
                      (cur_slot < MAX_STREAMS) && !lang_done[cur_slot[3:0]];
                sp_desc_left = b;
                sp_skip--;
                sp_shift = '0;
                sp_phase = next_desc_phase(cap ? pmt_pkg::PH_LANG0 : pmt_pkg::PH_SKIP);
            end
            pmt_pkg::PH_SKIP: begin
                sp_desc_left--;
                sp_skip--;
                sp_phase = next_desc_phase(pmt_pkg::PH_SKIP);
            end
            default: begin
                sp_shift = {sp_shift[31:0], b};
                sp_desc_left--;
                sp_skip--;
                if (sp_phase == pmt_pkg::PH_LANG3) begin
                    sp_phase = next_desc_phase(pmt_pkg::PH_SKIP);
                    if (cur_slot < MAX_STREAMS) begin
                        lang_done[cur_slot[3:0]] = 1'b1;
                        r.kind = pmt_pkg::KIND_LANG;
                        r.pid = pid_table[cur_slot[3:0]];
                        r.slot = cur_slot[3:0];
                        r.lang = sp_shift[31:8];
                        r.atype = sp_shift[7:0];
                        hit = 1'b1;
                    end
                end else begin
                    sp_phase = next_desc_phase(pmt_pkg::phase_t'(sp_phase + 4'd1));
                end
            end
        endcase
        return hit;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic sect_start,
                                    input bit pinned, input pmt_pkg::kind_t k,
                                    input logic [12:0] pid, input logic [7:0] st,
                                    input logic [9:0] ilen, input logic [3:0] slot,
                                    input logic is_new);
        stim_row_t row;
        row.data = b;
        row.sect_start = sect_start;
        row.pinned = pinned;
        row.pinned_res = '0;
        row.pinned_res.kind = k;
        row.pinned_res.pid = pid;
        row.pinned_res.stype = st;
        row.pinned_res.ilen = ilen;
        row.pinned_res.slot = slot;
        row.pinned_res.is_new = is_new;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [12:0] pick_pid();
        int r;
        logic [12:0] v;
        r = $urandom_range(0, 9);
        if (r < 5) return pid_pool[5'($urandom_range(0, PID_POOL - 1))];
        if (r == 5) return 13'h0000;
        if (r == 6) return 13'h1FFF;
        v = 13'($urandom);
        return v;
    endfunction

    task automatic send_item(input logic [7:0] b, input logic sect_start, input bit pinned,
                             input parse_result_t pinned_res);
        int gap;
        bit hit;
        parse_result_t r;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sect_start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        hit = parse_section_byte(b, sect_start, r);
        if (hit) section_results_q.push_back(pinned ? pinned_res : r);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (section_results_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_table_id(input logic [7:0] id);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= id;
        @(posedge aclk);
        cfg_we <= 1'b0;
        table_id_cfg = id;
    endtask

    task automatic send_random_section();
        logic [7:0]  body [$];
        logic [7:0]  desc [$];
        logic [7:0]  tid;
        logic [7:0]  rnd;
        logic [12:0] pid;
        logic [9:0]  pil;
        logic [9:0]  elen;
        logic [11:0] sl;
        int roll, n, n_es, n_desc, dlen, tag_roll, i, j, keep;

        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            n = $urandom_range(1, 10);
            for (i = 0; i < n; i++)
                send_item(8'($urandom), ($urandom_range(0, 5) == 0), 1'b0, '0);
            return;
        end
        if (roll < 7) drain_results();
        tid = table_id_cfg;
        if (roll >= 88) begin
            do tid = 8'($urandom); while (tid == table_id_cfg);
            send_item(tid, 1'b1, 1'b0, '0);
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) send_item(8'($urandom), 1'b0, 1'b0, '0);
            return;
        end

        pil = '0;
        roll = $urandom_range(0, 9);
        if (roll >= 9) pil = 10'($urandom);
        else if (roll >= 6) pil = 10'($urandom_range(1, 6));
        body.push_back(tid);
        body.push_back(8'h00);
        body.push_back(8'h00);
        repeat (5) body.push_back(8'($urandom));
        pid = 13'($urandom);
        rnd = 8'($urandom);
        body.push_back({rnd[7:5], pid[12:8]});
        body.push_back(pid[7:0]);
        rnd = 8'($urandom);
        body.push_back({rnd[7:2], pil[9:8]});
        body.push_back(pil[7:0]);
        for (i = 0; i < pil && i < 8; i++) body.push_back(8'($urandom));

        n_es = $urandom_range(0, 4);
        for (i = 0; i < n_es; i++) begin
            desc.delete();
            n_desc = $urandom_range(0, 3);
            for (j = 0; j < n_desc; j++) begin
                tag_roll = $urandom_range(0, 9);
                if (tag_roll < 4) dlen = $urandom_range(4, 7);
                else if (tag_roll < 6) dlen = $urandom_range(0, 3);
                else dlen = $urandom_range(0, 5);
                rnd = 8'($urandom);
                desc.push_back((tag_roll < 6) ? pmt_pkg::TAG_ISO639 : rnd);
                desc.push_back(dlen[7:0]);
                repeat (dlen) desc.push_back(8'($urandom));
            end
            elen = 10'(desc.size());
            roll = $urandom_range(0, 19);
            if (roll == 0) elen = 10'($urandom);
            else if (roll < 3 && desc.size() > 0)
                elen = 10'($urandom_range(0, desc.size() - 1));
            pid = pick_pid();
            body.push_back(8'($urandom));
            rnd = 8'($urandom);
            body.push_back({rnd[7:5], pid[12:8]});
            body.push_back(pid[7:0]);
            rnd = 8'($urandom);
            body.push_back({rnd[7:2], elen[9:8]});
            body.push_back(elen[7:0]);
            foreach (desc[k]) body.push_back(desc[k]);
        end

        sl = 12'(body.size() + 1);
        roll = $urandom_range(0, 19);
        if (roll == 0) sl = '0;
        else if (roll < 3) sl = 12'($urandom_range(0, body.size() + 4));
        else if (roll == 3) sl = 12'($urandom);
        rnd = 8'($urandom);
        body[1] = {rnd[7:4], sl[11:8]};
        body[2] = sl[7:0];
        repeat (4) body.push_back(8'($urandom));
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
        keep = body.size();
        if ($urandom_range(0, 19) == 0) keep = $urandom_range(1, body.size());
        for (i = 0; i < keep; i++) send_item(body[i], (i == 0), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left == 0) stall_left = pick_gap();
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        parse_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (section_results_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d tdata %h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = section_results_q.pop_front();
                check_field("kind",          32'(want.kind),   32'(m_tuser));
                check_field("pid",           32'(want.pid),    32'(m_tdata[12:0]));
                check_field("strm_type",     32'(want.stype),  32'(m_tdata[20:13]));
                check_field("info_length",   32'(want.ilen),   32'(m_tdata[30:21]));
                check_field("entry_index",   32'(want.slot),   32'(m_tdata[34:31]));
                check_field("is_new",        32'(want.is_new), 32'(m_tdata[35]));
                check_field("language_code", 32'(want.lang),   32'(m_tdata[59:36]));
                check_field("aud_type",      32'(want.atype),  32'(m_tdata[67:60]));
                check_field("tdata padding", 32'd0,            32'(m_tdata[71:68]));
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle = 0;
            else
                idle++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [7:0] phase_ids [5];
        int ph;
        for (ph = 0; ph < MAX_STREAMS; ph++) begin
            pid_table[ph[3:0]] = '0;
            pid_used[ph[3:0]]  = 1'b0;
            lang_done[ph[3:0]] = 1'b0;
        end
        for (ph = 0; ph < PID_POOL; ph++) pid_pool[ph[4:0]] = 13'($urandom);
        phase_ids[0] = pmt_pkg::TABLE_ID_RST;
        phase_ids[1] = 8'hFF;
        phase_ids[2] = 8'h00;
        phase_ids[3] = 8'($urandom);
        phase_ids[4] = pmt_pkg::TABLE_ID_RST;

        add_row(8'h00, 1'b1, 1'b1, pmt_pkg::KIND_BAD_ID, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'hFF, 1'b1, 1'b1, pmt_pkg::KIND_BAD_ID, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h55, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h02, 1'b1, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'hB0, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h20, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h01, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'hC1, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'hFC, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h00, 1'b0, 1'b1, pmt_pkg::KIND_HEADER, 13'h1FFF, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'hF0, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h06, 1'b0, 1'b1, pmt_pkg::KIND_STREAM, 13'h1FFF, 8'hFF, 10'd6, 4'd0, 1'b1);
        add_row(8'h0A, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h04, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h65, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h6E, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h67, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h01, 1'b0, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);
        add_row(8'h02, 1'b1, 1'b0, pmt_pkg::KIND_HEADER, 13'h0000, 8'h00, 10'd0, 4'd0, 1'b0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].data, directed_rows[i].sect_start,
                      directed_rows[i].pinned, directed_rows[i].pinned_res);

        for (ph = 0; ph < 5; ph++) begin
            if (ph > 0) set_table_id(phase_ids[ph[2:0]]);
            no_gaps = (ph == 2);
            while (items_sent < directed_rows.size() + (ph + 1) * PHASE_ITEMS)
                send_random_section();
        end
        no_gaps = 1'b0;

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> pmt_section_parser.f
rtl/core/pmt_pkg.sv
rtl/core/pmt_section_parser.sv
tb/testbench.sv
